@@ hw/rtl/windowed_average_and_trend_macros.svh @@
// assertion macros shared by the windowed average and trend rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef WINDOWED_AVERAGE_AND_TREND_MACROS_SVH
`define WINDOWED_AVERAGE_AND_TREND_MACROS_SVH

// same-cycle implication, disabled in reset
`define WAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define WAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/wat_pkg.sv @@
// shared types and constants for the windowed average and trend block
// no dependencies
`default_nettype none

package wat_pkg;

    localparam int SAMPLE_W = 32;
    localparam int MEAN_W   = 32;
    localparam int TREND_W  = 33;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WALK  = 6'b000010,
        S_MEAN  = 6'b000100,
        S_NEWER = 6'b001000,
        S_OLDER = 6'b010000,
        S_OUT   = 6'b100000
    } wat_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/wat_divider.sv @@
// serial signed divider, one quotient bit per cycle, truncates toward zero
// depends on wat_pkg and windowed_average_and_trend_macros.svh
`default_nettype none
`include "windowed_average_and_trend_macros.svh"

module wat_divider #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] dividend,
    input  logic        [DEN_W-1:0] divisor,
    output logic signed [NUM_W-1:0] quotient,
    output wat_pkg::div_stat_t      stat
);
    import wat_pkg::*;

    localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  dq_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic              neg_reg;

    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;
    logic              ge;

    assign shifted = {rem_reg, dq_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[NUM_W-1];
            dq_reg  <= dividend[NUM_W-1] ? (~dividend + 1'b1) : dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            dq_reg  <= {dq_reg[NUM_W-2:0], ge};
        end
    end

    assign quotient  = neg_reg ? (~dq_reg + 1'b1) : dq_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `WAT_ASSERT_NOW(a_no_restart, start, !busy_reg, "divider started while busy")
    `WAT_ASSERT_NOW(a_done_idle, done_reg, !busy_reg, "divider done while busy")
    `WAT_ASSERT_NOW(a_rem_bound, busy_reg && !start, rem_reg < den_reg,
        "divider remainder not below divisor")

endmodule

`default_nettype wire

@@ hw/rtl/windowed_average_and_trend.sv @@
// Running mean and trend over the last WINDOW_DEPTH signed 32-bit samples. Each
// accepted word is written into an on-chip ring, then the ring is walked newest
// first, one entry per cycle through its registered read port, and the quotients
// total/count, newer half/size and older half/size (the halves only with two or
// more words stored) go one after another through a shared bit-serial divider
// that spends one cycle per dividend bit. sample_ready is low from acceptance
// until the result is loaded into the output register. The result sits there,
// so the next word is taken while it waits. No clearing pass after reset.
// depends on wat_pkg, wat_divider and windowed_average_and_trend_macros.svh
`default_nettype none
`include "windowed_average_and_trend_macros.svh"

module windowed_average_and_trend #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  logic signed [31:0] sample,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [31:0] window_mean,
    output logic signed [32:0] window_trend
);
    import wat_pkg::*;

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = SAMPLE_W + 1 + AW;

    logic signed [SAMPLE_W-1:0] ring_mem [WINDOW_DEPTH];

    wat_state_t                 state_reg;
    wat_state_t                 state_next;
    logic [AW-1:0]              wp_reg;
    logic [CW-1:0]              cnt_reg;
    logic [AW-1:0]              rd_ptr_reg;
    logic [CW-1:0]              k_reg;
    logic                       pend_reg;
    logic                       pend_newer_reg;
    logic signed [SAMPLE_W-1:0] rdata_reg;
    logic signed [SW-1:0]       total_reg;
    logic signed [SW-1:0]       newer_reg;
    logic                       launched_reg;
    logic signed [MEAN_W-1:0]   mean_q_reg;
    logic signed [MEAN_W-1:0]   newer_q_reg;
    logic signed [MEAN_W-1:0]   older_q_reg;
    logic                       result_valid_reg;
    logic signed [MEAN_W-1:0]   window_mean_reg;
    logic signed [TREND_W-1:0]  window_trend_reg;

    logic                       accept;
    logic                       issue;
    logic [CW-1:0]              newer_n;
    logic [CW-1:0]              older_n;
    logic signed [SW-1:0]       rdata_ext;
    logic                       div_go;
    logic                       div_start;
    logic signed [SW-1:0]       div_num;
    logic [CW-1:0]              div_den;
    logic signed [SW-1:0]       div_quot;
    div_stat_t                  div_stat;
    logic                       out_load;
    logic signed [TREND_W-1:0]  trend_val;

    assign accept    = sample_valid && sample_ready;
    assign newer_n   = cnt_reg >> 1;
    assign older_n   = cnt_reg - newer_n;
    assign issue     = (state_reg == S_WALK) && (k_reg < cnt_reg);
    assign rdata_ext = {{(SW - SAMPLE_W){rdata_reg[SAMPLE_W-1]}}, rdata_reg};
    assign out_load  = (state_reg == S_OUT) && (!result_valid_reg || result_ready);
    assign trend_val = (cnt_reg < CW'(2)) ? '0 :
        ({newer_q_reg[MEAN_W-1], newer_q_reg} - {older_q_reg[MEAN_W-1], older_q_reg});

    always_comb
    begin
        div_go  = state_reg inside {S_MEAN, S_NEWER, S_OLDER};
        div_num = total_reg;
        div_den = cnt_reg;
        case (state_reg)
            S_NEWER:
            begin
                div_num = newer_reg;
                div_den = newer_n;
            end
            S_OLDER:
            begin
                div_num = total_reg - newer_reg;
                div_den = older_n;
            end
            default:
            begin
                div_num = total_reg;
                div_den = cnt_reg;
            end
        endcase
    end

    assign div_start = div_go && !launched_reg;

    wat_divider #(
        .NUM_W (SW),
        .DEN_W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_WALK;
            end
            S_WALK:
            begin
                if (!issue && !pend_reg)
                    state_next = S_MEAN;
            end
            S_MEAN:
            begin
                if (div_stat.done)
                    state_next = (cnt_reg < CW'(2)) ? S_OUT : S_NEWER;
            end
            S_NEWER:
            begin
                if (div_stat.done)
                    state_next = S_OLDER;
            end
            S_OLDER:
            begin
                if (div_stat.done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ring storage, registered read port
    always_ff @(posedge clk)
    begin
        if (accept)
            ring_mem[wp_reg] <= sample;
        rdata_reg <= ring_mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            wp_reg           <= '0;
            cnt_reg          <= '0;
            k_reg            <= '0;
            pend_reg         <= 1'b0;
            launched_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= issue;
            if (accept)
            begin
                wp_reg  <= (wp_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                cnt_reg <= (cnt_reg == CW'(WINDOW_DEPTH)) ? cnt_reg : cnt_reg + 1'b1;
                k_reg   <= '0;
            end
            else if (issue)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (div_start)
                launched_reg <= 1'b1;
            else if (div_stat.done)
                launched_reg <= 1'b0;
            if (out_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_ptr_reg <= wp_reg;
            total_reg  <= '0;
            newer_reg  <= '0;
        end
        else
        begin
            if (issue)
            begin
                rd_ptr_reg     <= (rd_ptr_reg == '0) ? AW'(WINDOW_DEPTH - 1)
                                                     : rd_ptr_reg - 1'b1;
                pend_newer_reg <= (k_reg < newer_n);
            end
            if (pend_reg)
            begin
                total_reg <= total_reg + rdata_ext;
                if (pend_newer_reg)
                    newer_reg <= newer_reg + rdata_ext;
            end
        end
        if (div_stat.done)
        begin
            if (state_reg == S_MEAN)
                mean_q_reg <= div_quot[MEAN_W-1:0];
            if (state_reg == S_NEWER)
                newer_q_reg <= div_quot[MEAN_W-1:0];
            if (state_reg == S_OLDER)
                older_q_reg <= div_quot[MEAN_W-1:0];
        end
        if (out_load)
        begin
            window_mean_reg  <= mean_q_reg;
            window_trend_reg <= trend_val;
        end
    end

    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign window_mean  = window_mean_reg;
    assign window_trend = window_trend_reg;

    `WAT_ASSERT_NOW(a_count_bound, 1'b1, cnt_reg <= CW'(WINDOW_DEPTH),
        "stored count above window depth")
    `WAT_ASSERT_NEXT(a_accept_walk, accept, state_reg == S_WALK,
        "accepted word did not start the walk")
    `WAT_ASSERT_NOW(a_div_free, div_start, !div_stat.busy,
        "divider launched while busy")
    `WAT_ASSERT_NOW(a_walk_ptr, state_reg == S_WALK, k_reg <= cnt_reg,
        "walk ran past the stored count")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for windowed_average_and_trend
// predicts running mean and half-window trend per sample word, compares each result word
// depends on wat_pkg and the windowed_average_and_trend rtl
`default_nettype none

module tb;

    import wat_pkg::*;

    localparam int DEPTH         = 16;
    localparam int DEPTH_AW      = $clog2(DEPTH);
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        logic signed [MEAN_W-1:0]  mean;
        logic signed [TREND_W-1:0] trend;
    } window_stats_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       sample_valid = 1'b0;
    logic                       sample_ready;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic signed [MEAN_W-1:0]   window_mean;
    logic signed [TREND_W-1:0]  window_trend;

    // predictor state
    logic signed [SAMPLE_W-1:0] hist_ring [DEPTH];
    int unsigned                hist_wp = 0;
    int unsigned                hist_count = 0;

    window_stats_t pending_stats [$];
    int            mismatch_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            quiet_cycles = 0;

    windowed_average_and_trend #(
        .WINDOW_DEPTH(DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample      (sample),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .window_mean (window_mean),
        .window_trend(window_trend)
    );

    always #6 clk = ~clk;

    function automatic window_stats_t push_and_average(input logic signed [SAMPLE_W-1:0] s);
        window_stats_t st;
        longint        total;
        longint        newer_total;
        longint        older_total;
        longint        newer_n;
        longint        older_n;
        longint        mean_l;
        longint        trend_l;
        int unsigned   pos;
        total       = 0;
        newer_total = 0;
        older_total = 0;
        hist_ring[DEPTH_AW'(hist_wp)] = s;
        hist_wp = (hist_wp + 1) % DEPTH;
        if (hist_count < DEPTH)
            hist_count++;
        for (int unsigned k = 0; k < hist_count; k++)
            total += longint'(hist_ring[DEPTH_AW'(k)]);
        mean_l  = total / longint'(hist_count);
        trend_l = 0;
        if (hist_count >= 2)
        begin
            newer_n = hist_count / 2;
            older_n = hist_count - newer_n;
            for (int unsigned k = 0; k < hist_count; k++)
            begin
                pos = (hist_wp + DEPTH - 1 - k) % DEPTH;
                if (k < newer_n)
                    newer_total += longint'(hist_ring[DEPTH_AW'(pos)]);
                else
                    older_total += longint'(hist_ring[DEPTH_AW'(pos)]);
            end
            trend_l = newer_total / newer_n - older_total / older_n;
        end
        st.mean  = mean_l[MEAN_W-1:0];
        st.trend = trend_l[TREND_W-1:0];
        return st;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int r;
        r = int'($urandom);
        case ($urandom_range(7))
            0, 1, 2: return r;
            3:       return $urandom_range(200) - 100;
            4:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            5:       return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(15)
                                              : 32'sh80000000 + $urandom_range(15);
            default: return r >>> $urandom_range(31);
        endcase
    endfunction

    // one sample word, with a random gap ahead of it
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        do
            @(posedge clk);
        while (!sample_ready);
        pending_stats.push_back(push_and_average(s));
    endtask

    task automatic send_random_samples(input int count);
        repeat (count)
            send_sample(pick_sample());
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        while (pending_stats.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_extremes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // first word alone gives zero trend, second gives a two-sample split
        send_sample(32'sh7fffffff);
        send_sample(32'sh7fffffff);
        send_sample(32'sh80000000);
        send_sample(32'sh80000000);
        send_sample(-32'sd1);
        send_sample(32'sd1);
        send_sample(32'sd0);
        send_sample(32'sh55555555);
        send_sample(32'shaaaaaaaa);
        // fill and wrap the window with alternating extremes
        for (int k = 0; k < 16; k++)
            send_sample(k[0] ? 32'sh80000000 : 32'sh7fffffff);
    endtask

    task automatic test_random_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_samples(400);
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct  = 48;
        recv_stall_pct = 0;
        send_random_samples(300);
    endtask

    task automatic test_random_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 48;
        send_random_samples(300);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        send_random_samples(300);
    endtask

    task automatic test_drain_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 31;
        send_random_samples(100);
        wait_drained();
        send_random_samples(100);
    endtask

    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_stats.size() == 0)
            begin
                $display("%0t: unexpected result word mean=%0d trend=%0d",
                         $time, window_mean, window_trend);
                mismatch_count++;
            end
            else
            begin
                window_stats_t want;
                want = pending_stats.pop_front();
                if (window_mean !== want.mean)
                begin
                    $display("%0t: window_mean expected %0d actual %0d",
                             $time, want.mean, window_mean);
                    mismatch_count++;
                end
                if (window_trend !== want.trend)
                begin
                    $display("%0t: window_trend expected %0d actual %0d",
                             $time, want.trend, window_trend);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_valid && sample_ready) || (result_valid && result_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_drain_pause();
        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && pending_stats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
